>>> hw/rtl/latitude_band_strip_triangulator_defines.svh
// assertion macros for the latitude band strip triangulator checker
// no dependencies; taken in by the checker file only
`ifndef LATITUDE_BAND_STRIP_TRIANGULATOR_DEFINES_SVH
`define LATITUDE_BAND_STRIP_TRIANGULATOR_DEFINES_SVH

// property checked at every clock edge outside reset
`define LBST_ASSERT_NOW(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lbst check failed");

// condition in the cycle after a trigger
`define LBST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   `LBST_ASSERT_NOW(lbl, clk, rst, (ante) |=> (cons))

`endif

>>> hw/rtl/lbst_pkg.sv
// shared constants and control structs for the latitude band strip triangulator
// no dependencies
package lbst_pkg;

   // default band capacity and node index width
   localparam int MAX_BAND_DEF  = 32;
   localparam int NODE_BITS_DEF = 24;

   // width of node index fields on the channels
   localparam int FIELD_W = 24;

   // sequencer to advancing front unit
   typedef struct packed {
      logic start;
      logic step;
   } front_ctrl_type;

   // advancing front unit to sequencer
   typedef struct packed {
      logic adv_up;
      logic last;
   } front_stat_type;

endpackage

>>> hw/rtl/lbst_channels.sv
// valid/ready channel interfaces for the point items and the triangle items
// depends on lbst_pkg
interface lbst_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [lbst_pkg::FIELD_W-1:0] node_index;
   logic                        end_of_band;

   modport source (output valid, output kind, output node_index, output end_of_band,
                   input ready);
   modport sink (input valid, input kind, input node_index, input end_of_band,
                 output ready);
endinterface

interface lbst_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lbst_pkg::FIELD_W-1:0] vertex_upper;
   logic [lbst_pkg::FIELD_W-1:0] vertex_lower;
   logic [lbst_pkg::FIELD_W-1:0] vertex_next;
   logic                        advanced_upper;
   logic                        last_of_strip;
   logic                        overflow;

   modport source (output valid, output vertex_upper, output vertex_lower,
                   output vertex_next, output advanced_upper, output last_of_strip,
                   output overflow, input ready);
   modport sink (input valid, input vertex_upper, input vertex_lower,
                 input vertex_next, input advanced_upper, input last_of_strip,
                 input overflow, output ready);
endinterface

>>> hw/rtl/lbst_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module lbst_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/lbst_front.sv
// advancing front unit: band positions, advance counts and the running
// cross products that pick which band advances; depends on lbst_pkg
module lbst_front #(
   parameter int MAX_BAND = lbst_pkg::MAX_BAND_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lbst_pkg::front_ctrl_type                 ctrl,
   input  logic [$clog2(MAX_BAND+1)-1:0]            n_upper,
   input  logic [$clog2(MAX_BAND+1)-1:0]            n_lower,
   output lbst_pkg::front_stat_type                 stat,
   output logic [((MAX_BAND > 1) ? $clog2(MAX_BAND) : 1)-1:0] next_index
);

   localparam int IDX_W = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
   localparam int CNT_W = $clog2(MAX_BAND + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int ACC_W = $clog2((MAX_BAND + 1) * MAX_BAND + 1);

   logic [CNT_W-1:0] nu_ff, nu_in, nl_ff, nl_in;
   logic [IDX_W-1:0] u_idx_ff, u_idx_in, l_idx_ff, l_idx_in;
   logic [CNT_W-1:0] u_adv_ff, u_adv_in, l_adv_ff, l_adv_in;
   logic [ACC_W-1:0] acc_u_ff, acc_u_in, acc_l_ff, acc_l_in;

   logic [CNT_W-1:0] u_inc, l_inc;
   logic [IDX_W-1:0] u_nxt, l_nxt;
   logic             adv_up;
   logic [SUM_W-1:0] done_sum, total_sum;

   // wrapped successor of each band position
   assign u_inc = CNT_W'(u_idx_ff) + CNT_W'(1);
   assign l_inc = CNT_W'(l_idx_ff) + CNT_W'(1);
   assign u_nxt = (u_inc >= nu_ff) ? '0 : IDX_W'(u_inc);
   assign l_nxt = (l_inc >= nl_ff) ? '0 : IDX_W'(l_inc);

   // (u_adv+1)*n_lower <= (l_adv+1)*n_upper kept as running sums, ties go up
   always_comb begin
      if (u_adv_ff >= nu_ff) begin
         adv_up = 1'b0;
      end else if (l_adv_ff >= nl_ff) begin
         adv_up = 1'b1;
      end else begin
         adv_up = (acc_u_ff <= acc_l_ff);
      end
   end

   // final triangle once all but one advance are made
   assign done_sum  = SUM_W'(u_adv_ff) + SUM_W'(l_adv_ff) + SUM_W'(1);
   assign total_sum = SUM_W'(nu_ff) + SUM_W'(nl_ff);

   assign stat.adv_up = adv_up;
   assign stat.last   = (done_sum == total_sum);
   assign next_index  = adv_up ? u_nxt : l_nxt;

   // front update
   always_comb begin
      nu_in    = nu_ff;
      nl_in    = nl_ff;
      u_idx_in = u_idx_ff;
      l_idx_in = l_idx_ff;
      u_adv_in = u_adv_ff;
      l_adv_in = l_adv_ff;
      acc_u_in = acc_u_ff;
      acc_l_in = acc_l_ff;
      if (ctrl.start) begin
         nu_in    = n_upper;
         nl_in    = n_lower;
         u_idx_in = '0;
         l_idx_in = '0;
         u_adv_in = '0;
         l_adv_in = '0;
         acc_u_in = ACC_W'(n_lower);
         acc_l_in = ACC_W'(n_upper);
      end else if (ctrl.step) begin
         if (adv_up) begin
            u_idx_in = u_nxt;
            u_adv_in = u_adv_ff + CNT_W'(1);
            acc_u_in = acc_u_ff + ACC_W'(nl_ff);
         end else begin
            l_idx_in = l_nxt;
            l_adv_in = l_adv_ff + CNT_W'(1);
            acc_l_in = acc_l_ff + ACC_W'(nu_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nu_ff    <= '0;
         nl_ff    <= '0;
         u_idx_ff <= '0;
         l_idx_ff <= '0;
         u_adv_ff <= '0;
         l_adv_ff <= '0;
         acc_u_ff <= '0;
         acc_l_ff <= '0;
      end else begin
         nu_ff    <= nu_in;
         nl_ff    <= nl_in;
         u_idx_ff <= u_idx_in;
         l_idx_ff <= l_idx_in;
         u_adv_ff <= u_adv_in;
         l_adv_ff <= l_adv_in;
         acc_u_ff <= acc_u_in;
         acc_l_ff <= acc_l_in;
      end
   end

endmodule

>>> hw/rtl/latitude_band_strip_triangulator.sv
// top level of the latitude band strip triangulator: band store, sequencer,
// output register; depends on lbst_pkg, lbst_channels, lbst_ram, lbst_front
//
// Points arrive one item per cycle while the block is idle; a point is
// written into the half of the band store that holds the band being filled,
// and points beyond MAX_BAND are dropped and flagged. An item of kind 1
// forgets both bands. When an end-of-band point closes a band and a previous
// band exists, the block stops taking items and runs one strip of
// n_upper + n_lower triangles: it first fetches the first point of each band
// (S_FETCH_U, then S_FETCH_L), then for each triangle reads the next point
// of the advanced band through the single store read port (S_READ) and
// loads the output register (S_EMIT), where it waits while the output stalls.
// The band store has no reset and needs no clearing pass.
module latitude_band_strip_triangulator #(
   parameter int MAX_BAND  = lbst_pkg::MAX_BAND_DEF,
   parameter int NODE_BITS = lbst_pkg::NODE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lbst_req_if.sink   req_chan,
   lbst_rsp_if.source rsp_chan
);

   localparam int DEPTH   = 2 * MAX_BAND;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int IDX_W   = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
   localparam int CNT_W   = $clog2(MAX_BAND + 1);
   localparam int FIELD_W = lbst_pkg::FIELD_W;
   localparam int STORE_W = (NODE_BITS < FIELD_W) ? NODE_BITS : FIELD_W;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_FETCH_U = 5'b00010,
      S_FETCH_L = 5'b00100,
      S_READ    = 5'b01000,
      S_EMIT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic             cur_half_ff, cur_half_in;
   logic [CNT_W-1:0] cur_count_ff, cur_count_in;
   logic [CNT_W-1:0] prev_count_ff, prev_count_in;
   logic             have_prev_ff, have_prev_in;
   logic             prev_ovf_ff, prev_ovf_in;
   logic             cur_ovf_ff, cur_ovf_in;

   logic             lo_half_ff, lo_half_in;
   logic             strip_ovf_ff, strip_ovf_in;
   logic             first_ff, first_in;
   logic             adv_ff, adv_in;
   logic             last_ff, last_in;
   logic [STORE_W-1:0] cur_upper_ff, cur_upper_in;
   logic [STORE_W-1:0] cur_lower_ff, cur_lower_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_upper_ff, rsp_upper_in;
   logic [FIELD_W-1:0] rsp_lower_ff, rsp_lower_in;
   logic [FIELD_W-1:0] rsp_next_ff, rsp_next_in;
   logic               rsp_adv_ff, rsp_adv_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               accept, point, has_room, close_band, run_strip, out_free;
   logic [CNT_W-1:0]   cnt_after;
   logic               ovf_after;
   logic               wr_en, rd_en, rd_half;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [STORE_W-1:0] wr_data, rd_data;
   logic [IDX_W-1:0]   rd_index, next_index;

   lbst_pkg::front_ctrl_type front_ctrl;
   lbst_pkg::front_stat_type front_stat;

   // item acceptance and band fill
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept     = req_chan.valid && req_chan.ready;
   assign point      = accept && !req_chan.kind;
   assign has_room   = (cur_count_ff < CNT_W'(MAX_BAND));
   assign cnt_after  = has_room ? (cur_count_ff + CNT_W'(1)) : cur_count_ff;
   assign ovf_after  = cur_ovf_ff || !has_room;
   assign close_band = point && req_chan.end_of_band;
   assign run_strip  = close_band && have_prev_ff && (prev_count_ff != '0) &&
                       (cnt_after != '0);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   // store write into the half being filled
   assign wr_en   = point && has_room;
   assign wr_data = STORE_W'(req_chan.node_index);
   assign wr_addr = cur_half_ff ? (ADDR_W'(MAX_BAND) + ADDR_W'(cur_count_ff))
                                : ADDR_W'(cur_count_ff);

   // store read address
   assign rd_addr = rd_half ? (ADDR_W'(MAX_BAND) + ADDR_W'(rd_index)) : ADDR_W'(rd_index);

   lbst_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_band_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lbst_front #(
      .MAX_BAND (MAX_BAND)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (front_ctrl),
      .n_upper    (prev_count_ff),
      .n_lower    (cnt_after),
      .stat       (front_stat),
      .next_index (next_index)
   );

   // sequencer and band bookkeeping
   always_comb begin
      state_in      = state_ff;
      cur_half_in   = cur_half_ff;
      cur_count_in  = cur_count_ff;
      prev_count_in = prev_count_ff;
      have_prev_in  = have_prev_ff;
      prev_ovf_in   = prev_ovf_ff;
      cur_ovf_in    = cur_ovf_ff;
      lo_half_in    = lo_half_ff;
      strip_ovf_in  = strip_ovf_ff;
      first_in      = first_ff;
      adv_in        = adv_ff;
      last_in       = last_ff;
      cur_upper_in  = cur_upper_ff;
      cur_lower_in  = cur_lower_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_upper_in  = rsp_upper_ff;
      rsp_lower_in  = rsp_lower_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_adv_in    = rsp_adv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rd_en         = 1'b0;
      rd_half       = lo_half_ff;
      rd_index      = '0;
      front_ctrl    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_chan.kind) begin
               // restart: forget both bands
               cur_count_in  = '0;
               prev_count_in = '0;
               have_prev_in  = 1'b0;
               prev_ovf_in   = 1'b0;
               cur_ovf_in    = 1'b0;
            end else if (point) begin
               cur_count_in = cnt_after;
               cur_ovf_in   = ovf_after;
               if (close_band) begin
                  // closed band becomes the previous band
                  prev_count_in = cnt_after;
                  prev_ovf_in   = ovf_after;
                  have_prev_in  = 1'b1;
                  cur_half_in   = !cur_half_ff;
                  cur_count_in  = '0;
                  cur_ovf_in    = 1'b0;
               end
               if (run_strip) begin
                  lo_half_in       = cur_half_ff;
                  strip_ovf_in     = prev_ovf_ff || ovf_after;
                  front_ctrl.start = 1'b1;
                  state_in         = S_FETCH_U;
               end
            end
         end
         S_FETCH_U: begin
            // first point of the upper band
            rd_en    = 1'b1;
            rd_half  = !lo_half_ff;
            state_in = S_FETCH_L;
         end
         S_FETCH_L: begin
            // first point of the lower band
            rd_en        = 1'b1;
            rd_half      = lo_half_ff;
            cur_upper_in = rd_data;
            first_in     = 1'b1;
            state_in     = S_READ;
         end
         S_READ: begin
            // pick the band to advance and fetch its next point
            if (first_ff) begin
               cur_lower_in = rd_data;
               first_in     = 1'b0;
            end
            rd_en           = 1'b1;
            rd_half         = front_stat.adv_up ? !lo_half_ff : lo_half_ff;
            rd_index        = next_index;
            adv_in          = front_stat.adv_up;
            last_in         = front_stat.last;
            front_ctrl.step = 1'b1;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            // hand the triangle to the output register
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_upper_in = FIELD_W'(cur_upper_ff);
               rsp_lower_in = FIELD_W'(cur_lower_ff);
               rsp_next_in  = FIELD_W'(rd_data);
               rsp_adv_in   = adv_ff;
               rsp_last_in  = last_ff;
               rsp_ovf_in   = strip_ovf_ff;
               if (adv_ff) begin
                  cur_upper_in = rd_data;
               end else begin
                  cur_lower_in = rd_data;
               end
               state_in = last_ff ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_half_ff   <= 1'b0;
         cur_count_ff  <= '0;
         prev_count_ff <= '0;
         have_prev_ff  <= 1'b0;
         prev_ovf_ff   <= 1'b0;
         cur_ovf_ff    <= 1'b0;
         first_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_half_ff   <= cur_half_in;
         cur_count_ff  <= cur_count_in;
         prev_count_ff <= prev_count_in;
         have_prev_ff  <= have_prev_in;
         prev_ovf_ff   <= prev_ovf_in;
         cur_ovf_ff    <= cur_ovf_in;
         first_ff      <= first_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // strip payload and output register
   always_ff @(posedge clock) begin
      lo_half_ff   <= lo_half_in;
      strip_ovf_ff <= strip_ovf_in;
      adv_ff       <= adv_in;
      last_ff      <= last_in;
      cur_upper_ff <= cur_upper_in;
      cur_lower_ff <= cur_lower_in;
      rsp_upper_ff <= rsp_upper_in;
      rsp_lower_ff <= rsp_lower_in;
      rsp_next_ff  <= rsp_next_in;
      rsp_adv_ff   <= rsp_adv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.vertex_upper   = rsp_upper_ff;
   assign rsp_chan.vertex_lower   = rsp_lower_ff;
   assign rsp_chan.vertex_next    = rsp_next_ff;
   assign rsp_chan.advanced_upper = rsp_adv_ff;
   assign rsp_chan.last_of_strip  = rsp_last_ff;
   assign rsp_chan.overflow       = rsp_ovf_ff;

endmodule

>>> hw/rtl/lbst_checker.sv
// port level checks for the latitude band strip triangulator, bound to the top
// depends on lbst_pkg and latitude_band_strip_triangulator_defines.svh
`include "latitude_band_strip_triangulator_defines.svh"

module lbst_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_kind,
   input logic                         req_end_of_band,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [lbst_pkg::FIELD_W-1:0] rsp_vertex_upper,
   input logic [lbst_pkg::FIELD_W-1:0] rsp_vertex_lower,
   input logic [lbst_pkg::FIELD_W-1:0] rsp_vertex_next,
   input logic                         rsp_advanced_upper,
   input logic                         rsp_last_of_strip,
   input logic                         rsp_overflow
);

   logic [3*lbst_pkg::FIELD_W+2:0] rsp_word;
   logic                           quiet_item;
   logic                           rsp_stall;
   logic                           mid_strip_take;

   assign rsp_word = {rsp_vertex_upper, rsp_vertex_lower, rsp_vertex_next,
                      rsp_advanced_upper, rsp_last_of_strip, rsp_overflow};

   // an accepted restart or mid-band point with no pending triangle starts no strip
   assign quiet_item = req_valid && req_ready && (req_kind || !req_end_of_band) && !rsp_valid;

   // triangle waiting, and a triangle taken that is not the last of its strip
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign mid_strip_take = rsp_valid && rsp_ready && !rsp_last_of_strip;

   // stalled triangle holds
   `LBST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // no point is taken while a strip is still being produced
   `LBST_ASSERT_NOW(a_busy_in_strip, clock, reset, (rsp_valid && !rsp_last_of_strip) |-> !req_ready)

   // items that close no band produce no triangle
   `LBST_ASSERT_NEXT(a_quiet_item, clock, reset, quiet_item, !rsp_valid)

   // overflow flag stays put between triangles of one strip
   `LBST_ASSERT_NEXT(a_strip_ovf, clock, reset, mid_strip_take, $stable(rsp_overflow))

endmodule

bind latitude_band_strip_triangulator lbst_checker u_lbst_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_kind           (req_chan.kind),
   .req_end_of_band    (req_chan.end_of_band),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_vertex_upper   (rsp_chan.vertex_upper),
   .rsp_vertex_lower   (rsp_chan.vertex_lower),
   .rsp_vertex_next    (rsp_chan.vertex_next),
   .rsp_advanced_upper (rsp_chan.advanced_upper),
   .rsp_last_of_strip  (rsp_chan.last_of_strip),
   .rsp_overflow       (rsp_chan.overflow)
);

>>> sim/latitude_band_strip_triangulator_test.sv
// testbench for the latitude band strip triangulator: sends point items, predicts every
// triangle of each strip from its own band store and checks the triangle items in order
// depends on lbst_pkg, lbst_channels and the latitude_band_strip_triangulator rtl
module latitude_band_strip_triangulator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BAND = lbst_pkg::MAX_BAND_DEF;
   localparam int W = lbst_pkg::FIELD_W;
   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   // item kinds on the point channel
   localparam bit KIND_POINT = 1'b0;
   localparam bit KIND_RESTART = 1'b1;

   typedef struct packed {
      logic [W-1:0] vertex_upper;
      logic [W-1:0] vertex_lower;
      logic [W-1:0] vertex_next;
      logic         advanced_upper;
      logic         last_of_strip;
      logic         overflow;
   } facet_type;

   logic clock;
   logic reset;

   lbst_req_if req_chan ();
   lbst_rsp_if rsp_chan ();

   latitude_band_strip_triangulator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state: two halves of the band store plus counts and drop flags
   logic [W-1:0] band_mem [0:2*MAX_BAND-1];
   bit           filling_half;
   int           upper_count;
   int           filling_count;
   bit           have_upper;
   bit           upper_dropped;
   bit           filling_dropped;

   facet_type    facet_queue [$];
   int           fault_count;
   int           send_idle_pct;
   int           drain_stall_pct;
   longint       cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL latitude_band_strip_triangulator");
         $finish;
      end
   end

   // advancing front over the upper (previous) and lower (just closed) bands
   function automatic void queue_strip();
      int        up_base;
      int        lo_base;
      int        nu;
      int        nl;
      int        u;
      int        l;
      int        u_adv;
      int        l_adv;
      int        total;
      int        t;
      bit        adv_up;
      facet_type facet;
      up_base = filling_half ? 0 : MAX_BAND;
      lo_base = filling_half ? MAX_BAND : 0;
      nu = upper_count;
      nl = filling_count;
      u = 0;
      l = 0;
      u_adv = 0;
      l_adv = 0;
      total = nu + nl;
      for (t = 0; t < total; t++) begin
         // exhausted band stops; ties go to the upper band
         if (u_adv >= nu)
            adv_up = 1'b0;
         else if (l_adv >= nl)
            adv_up = 1'b1;
         else
            adv_up = (u_adv + 1) * nl <= (l_adv + 1) * nu;
         facet.vertex_upper = band_mem[up_base + u];
         facet.vertex_lower = band_mem[lo_base + l];
         if (adv_up) begin
            u = (u + 1 >= nu) ? 0 : u + 1;
            facet.vertex_next = band_mem[up_base + u];
            u_adv++;
         end else begin
            l = (l + 1 >= nl) ? 0 : l + 1;
            facet.vertex_next = band_mem[lo_base + l];
            l_adv++;
         end
         facet.advanced_upper = adv_up;
         facet.last_of_strip = (t + 1 == total);
         facet.overflow = upper_dropped || filling_dropped;
         facet_queue.push_back(facet);
      end
   endfunction

   // state update for one accepted item
   function automatic void take_point(bit kind, logic [W-1:0] node, bit eob);
      if (kind == KIND_RESTART) begin
         upper_count = 0;
         filling_count = 0;
         have_upper = 1'b0;
         upper_dropped = 1'b0;
         filling_dropped = 1'b0;
         return;
      end
      if (filling_count < MAX_BAND) begin
         band_mem[(filling_half ? MAX_BAND : 0) + filling_count] = node;
         filling_count++;
      end else begin
         filling_dropped = 1'b1;
      end
      if (eob) begin
         if (have_upper && upper_count > 0 && filling_count > 0)
            queue_strip();
         upper_count = filling_count;
         upper_dropped = filling_dropped;
         have_upper = 1'b1;
         filling_half = ~filling_half;
         filling_count = 0;
         filling_dropped = 1'b0;
      end
   endfunction

   function automatic logic [W-1:0] pick_node();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return r[W-1:0];
      endcase
   endfunction

   // send one item; valid stays high afterwards so items can follow back to back
   task automatic send_point(bit kind, logic [W-1:0] node, bit eob);
      int gap;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 11);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.node_index <= node;
      req_chan.end_of_band <= eob;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      take_point(kind, node, eob);
   endtask

   task automatic send_band(int size);
      int i;
      for (i = 0; i < size; i++)
         send_point(KIND_POINT, pick_node(), i == size - 1);
   endtask

   // drop valid and let every predicted triangle come out
   task automatic wait_for_strips();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (facet_queue.size() != 0) @(posedge clock);
   endtask

   task automatic note_fault(string what, facet_type want, facet_type got);
      string want_text;
      string got_text;
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         want_text = $sformatf("expected up %h lo %h nx %h adv %b last %b ovf %b",
                               want.vertex_upper, want.vertex_lower, want.vertex_next,
                               want.advanced_upper, want.last_of_strip, want.overflow);
         got_text = $sformatf("got up %h lo %h nx %h adv %b last %b ovf %b",
                              got.vertex_upper, got.vertex_lower, got.vertex_next,
                              got.advanced_upper, got.last_of_strip, got.overflow);
         $display("%s at cycle %0d: %s, %s", what, cycle_count, want_text, got_text);
      end
   endtask

   // triangle side: ready with random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (drain_stall_pct > 0 && $urandom_range(0, 99) < drain_stall_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // compare each accepted triangle with the oldest prediction
   always @(posedge clock) begin
      facet_type want;
      facet_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.vertex_upper = rsp_chan.vertex_upper;
         got.vertex_lower = rsp_chan.vertex_lower;
         got.vertex_next = rsp_chan.vertex_next;
         got.advanced_upper = rsp_chan.advanced_upper;
         got.last_of_strip = rsp_chan.last_of_strip;
         got.overflow = rsp_chan.overflow;
         if (facet_queue.size() == 0) begin
            note_fault("unexpected triangle", '0, got);
         end else begin
            want = facet_queue.pop_front();
            if (got.vertex_upper !== want.vertex_upper ||
                got.vertex_lower !== want.vertex_lower ||
                got.vertex_next !== want.vertex_next ||
                got.advanced_upper !== want.advanced_upper ||
                got.last_of_strip !== want.last_of_strip ||
                got.overflow !== want.overflow)
               note_fault("triangle mismatch", want, got);
         end
      end
   end

   // small bands: first band, restarts, single points, ties, extremes of the index
   task automatic test_directed_strips();
      send_idle_pct = 0;
      drain_stall_pct = 0;
      send_point(KIND_RESTART, '1, 1'b1);
      // first band gives nothing
      send_point(KIND_POINT, '0, 1'b1);
      // one point over one point
      send_point(KIND_POINT, '1, 1'b1);
      // one over two, then two over three
      send_point(KIND_POINT, 24'h000001, 1'b0);
      send_point(KIND_POINT, 24'h800000, 1'b1);
      send_point(KIND_POINT, 24'h555555, 1'b0);
      send_point(KIND_POINT, 24'hAAAAAA, 1'b0);
      send_point(KIND_POINT, 24'h7FFFFF, 1'b1);
      // restart part way through a band, then a fresh first band
      send_point(KIND_POINT, 24'h123456, 1'b0);
      send_point(KIND_RESTART, '0, 1'b0);
      send_point(KIND_POINT, 24'hABCDEF, 1'b1);
      // one over two, two over four (with ties), four over one
      send_point(KIND_POINT, 24'h0F0F0F, 1'b0);
      send_point(KIND_POINT, 24'hF0F0F0, 1'b1);
      send_point(KIND_POINT, 24'h000010, 1'b0);
      send_point(KIND_POINT, 24'h000020, 1'b0);
      send_point(KIND_POINT, 24'h000030, 1'b0);
      send_point(KIND_POINT, 24'h000040, 1'b1);
      send_point(KIND_POINT, 24'hFFFFFE, 1'b1);
      wait_for_strips();
   endtask

   // full bands, the longest strip and points dropped past capacity
   task automatic test_full_bands();
      send_idle_pct = 20;
      drain_stall_pct = 20;
      send_point(KIND_RESTART, pick_node(), 1'($urandom_range(0, 1)));
      send_band(MAX_BAND);
      send_band(MAX_BAND);
      // end of band carried by a dropped point still closes the band
      send_band(MAX_BAND + 2);
      // overflow carried over from the upper band
      send_band(1);
      send_band(1);
      wait_for_strips();
   endtask

   // mostly well-formed bands of random content, with restarts and stray points
   task automatic test_random_meshes(int n_items, bit vary_idling);
      int sent;
      int pick;
      int size;
      sent = 0;
      while (sent < n_items) begin
         if (vary_idling && $urandom_range(0, 9) == 0) begin
            send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
            drain_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
         end
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_point(KIND_RESTART, pick_node(), 1'($urandom_range(0, 1)));
            sent++;
         end else if (pick < 10) begin
            send_point(KIND_POINT, pick_node(), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
               size = $urandom_range(1, 6);
            else if (pick < 95)
               size = $urandom_range(7, MAX_BAND);
            else
               size = $urandom_range(MAX_BAND + 1, MAX_BAND + 4);
            send_band(size);
            sent += size;
         end
      end
      wait_for_strips();
   endtask

   initial begin
      fault_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      drain_stall_pct = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.kind <= KIND_POINT;
      req_chan.node_index <= '0;
      req_chan.end_of_band <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_strips();
      test_full_bands();
      send_idle_pct = 25;
      drain_stall_pct = 25;
      test_random_meshes(170, 1'b1);
      // closing stretch without idling on either side
      send_idle_pct = 0;
      drain_stall_pct = 0;
      test_random_meshes(60, 1'b0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("PASS latitude_band_strip_triangulator");
      else
         $display("FAIL latitude_band_strip_triangulator");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lbst_pkg.sv
hw/rtl/lbst_channels.sv
hw/rtl/lbst_ram.sv
hw/rtl/lbst_front.sv
hw/rtl/latitude_band_strip_triangulator.sv
hw/rtl/lbst_checker.sv
sim/latitude_band_strip_triangulator_test.sv
